FILE: design/global_sequence_aligner_macros.svh
// Assertion macros for the sequence aligner.
`ifndef GLOBAL_SEQUENCE_ALIGNER_MACROS_SVH
`define GLOBAL_SEQUENCE_ALIGNER_MACROS_SVH
`ifndef SYNTHESIS
`define GSA_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GSA_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define GSA_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define GSA_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

FILE: design/gsa_pkg.sv
`default_nettype none
package gsa_pkg;
    localparam int MaxLenDefault = 32;
    localparam int ScoreWidthDefault = 12;

    localparam logic [1:0] CmdLoadFirst = 2'd0;
    localparam logic [1:0] CmdLoadSecond = 2'd1;
    localparam logic [1:0] CmdAlign = 2'd2;

    localparam logic [1:0] DirDiag = 2'd0;
    localparam logic [1:0] DirUp = 2'd1;
    localparam logic [1:0] DirLeft = 2'd2;

    localparam logic [1:0] RegMatch = 2'd0;
    localparam logic [1:0] RegMismatch = 2'd1;
    localparam logic [1:0] RegGap = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_FILL,
        ST_TB_READ,
        ST_TB_EMIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic init_row;
        logic fill_step;
        logic tb_read;
        logic tb_step;
        logic out_load;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic fill_row_end;
        logic fill_done;
        logic tb_done;
        logic tb_last;
    } stat_t;
endpackage
`default_nettype wire

FILE: design/gsa_in_if.sv
`default_nettype none
interface gsa_in_if;
    logic valid;
    logic ready;
    logic [1:0] cmd;
    logic [7:0] symbol;
    modport source (output valid, cmd, symbol, input ready);
    modport sink (input valid, cmd, symbol, output ready);
endinterface
`default_nettype wire

FILE: design/gsa_out_if.sv
`default_nettype none
interface gsa_out_if #(parameter int SCORE_WIDTH = 12);
    logic valid;
    logic ready;
    logic signed [SCORE_WIDTH-1:0] score;
    logic [7:0] first_symbol;
    logic first_is_gap;
    logic [7:0] second_symbol;
    logic second_is_gap;
    logic last;
    logic status;
    modport source (output valid, score, first_symbol, first_is_gap, second_symbol,
        second_is_gap, last, status, input ready);
    modport sink (input valid, score, first_symbol, first_is_gap, second_symbol,
        second_is_gap, last, status, output ready);
endinterface
`default_nettype wire

FILE: design/gsa_ram.sv
`default_nettype none
module gsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: design/gsa_ctrl.sv
`default_nettype none
`include "global_sequence_aligner_macros.svh"
module gsa_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic [1:0]     in_cmd,
    output logic                in_ready,
    input  wire logic           out_valid,
    input  wire logic           out_ready,
    input  wire logic           empty,
    input  wire gsa_pkg::stat_t stat,
    output gsa_pkg::cmd_t       cmd
);
    gsa_pkg::state_t state_reg, state_next;
    logic accept;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gsa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gsa_pkg::ST_IDLE:
            begin
                if (accept && in_cmd == gsa_pkg::CmdAlign)
                begin
                    state_next = empty ? gsa_pkg::ST_IDLE : gsa_pkg::ST_INIT;
                end
            end
            gsa_pkg::ST_INIT:
            begin
                state_next = gsa_pkg::ST_FILL;
            end
            gsa_pkg::ST_FILL:
            begin
                if (stat.fill_done)
                begin
                    state_next = gsa_pkg::ST_TB_READ;
                end
                else if (stat.fill_row_end)
                begin
                    state_next = gsa_pkg::ST_INIT;
                end
            end
            gsa_pkg::ST_TB_READ:
            begin
                state_next = gsa_pkg::ST_TB_EMIT;
            end
            gsa_pkg::ST_TB_EMIT:
            begin
                if (!out_valid || out_ready)
                begin
                    state_next = stat.tb_last ? gsa_pkg::ST_DONE : gsa_pkg::ST_TB_READ;
                end
            end
            gsa_pkg::ST_DONE:
            begin
                state_next = gsa_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = gsa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            gsa_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = accept && (in_cmd == gsa_pkg::CmdLoadFirst
                    || in_cmd == gsa_pkg::CmdLoadSecond);
                cmd.clear = accept && in_cmd == gsa_pkg::CmdAlign && empty;
                cmd.init_row = accept && in_cmd == gsa_pkg::CmdAlign && !empty;
            end
            gsa_pkg::ST_INIT:
            begin
                cmd.fill_step = 1'b0;
            end
            gsa_pkg::ST_FILL:
            begin
                cmd.fill_step = 1'b1;
            end
            gsa_pkg::ST_TB_READ:
            begin
                cmd.tb_read = 1'b1;
            end
            gsa_pkg::ST_TB_EMIT:
            begin
                if (!out_valid || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    cmd.tb_step = 1'b1;
                end
            end
            gsa_pkg::ST_DONE:
            begin
                cmd.clear = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    `GSA_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ready |-> state_reg == gsa_pkg::ST_IDLE, "ready outside idle")
    `GSA_ASSERT_IMPL(a_emit_stall, clk, rst_n, (state_reg == gsa_pkg::ST_TB_EMIT && out_valid && !out_ready) |=> state_reg == gsa_pkg::ST_TB_EMIT, "emit left under stall")
    `GSA_ASSERT_IMPL(a_done_idle, clk, rst_n, state_reg == gsa_pkg::ST_DONE |=> state_reg == gsa_pkg::ST_IDLE, "done not followed by idle")
endmodule
`default_nettype wire

FILE: design/gsa_dp.sv
`default_nettype none
`include "global_sequence_aligner_macros.svh"
module gsa_dp #(
    parameter int MAX_LEN = gsa_pkg::MaxLenDefault,
    parameter int SCORE_WIDTH = gsa_pkg::ScoreWidthDefault
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire gsa_pkg::cmd_t           cmd,
    input  wire logic [1:0]              in_cmd,
    input  wire logic [7:0]              in_symbol,
    input  wire logic signed [4:0]       match_score,
    input  wire logic signed [4:0]       mismatch_score,
    input  wire logic signed [4:0]       gap_score,
    input  wire logic                    out_ready,
    output logic                         empty,
    output gsa_pkg::stat_t               stat,
    gsa_out_if.source                    out
);
    localparam int IW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = 2 * IW;
    localparam logic [LW-1:0] MaxLenL = LW'(MAX_LEN);
    localparam logic signed [SCORE_WIDTH+1:0] Hi = (SCORE_WIDTH+2)'((1 << (SCORE_WIDTH-1)) - 1);
    localparam logic signed [SCORE_WIDTH+1:0] Lo = -Hi - 1;

    logic [7:0] seq_a_reg [MAX_LEN];
    logic [7:0] seq_b_reg [MAX_LEN];
    logic [LW-1:0] len_a_reg, len_b_reg;
    logic ovf_reg;
    logic signed [SCORE_WIDTH-1:0] row0_reg;
    logic signed [SCORE_WIDTH-1:0] row_reg [MAX_LEN];
    logic signed [SCORE_WIDTH-1:0] diag_reg, score_reg;
    logic [LW-1:0] i_reg, j_reg;
    logic [1:0] dir_rd;
    logic dir_we;
    logic [AW-1:0] dir_waddr, dir_raddr;
    logic [1:0] dir_wdata;
    logic out_valid_reg;
    logic signed [SCORE_WIDTH-1:0] out_score_reg;
    logic [7:0] out_a_reg, out_b_reg;
    logic out_agap_reg, out_bgap_reg, out_last_reg, out_status_reg;

    function automatic logic signed [SCORE_WIDTH-1:0] sat_add(
        input logic signed [SCORE_WIDTH-1:0] a, input logic signed [4:0] b);
        logic signed [SCORE_WIDTH+1:0] s;
        begin
            s = (SCORE_WIDTH+2)'(a) + (SCORE_WIDTH+2)'(b);
            if (s > Hi) s = Hi;
            if (s < Lo) s = Lo;
            return s[SCORE_WIDTH-1:0];
        end
    endfunction

    assign empty = (len_a_reg == '0) && (len_b_reg == '0);

    logic [IW-1:0] ia, jb;
    logic eq;
    logic signed [SCORE_WIDTH-1:0] up_cell, left_cell;
    logic signed [SCORE_WIDTH-1:0] d_s, u_s, l_s, best;
    logic [1:0] dir;
    assign ia = IW'(i_reg - LW'(1));
    assign jb = IW'(j_reg - LW'(1));
    assign eq = seq_a_reg[ia] == seq_b_reg[jb];
    assign up_cell = row_reg[jb];
    assign left_cell = (j_reg == LW'(1)) ? row0_reg : row_reg[IW'(j_reg - LW'(2))];
    assign d_s = sat_add(diag_reg, eq ? match_score : mismatch_score);
    assign u_s = sat_add(up_cell, gap_score);
    assign l_s = sat_add(left_cell, gap_score);
    always_comb
    begin
        best = d_s;
        dir = gsa_pkg::DirDiag;
        if (u_s > best)
        begin
            best = u_s;
            dir = gsa_pkg::DirUp;
        end
        if (l_s > best)
        begin
            best = l_s;
            dir = gsa_pkg::DirLeft;
        end
    end

    assign stat.fill_row_end = cmd.fill_step && (j_reg >= len_b_reg);
    assign stat.fill_done = stat.fill_row_end && (i_reg >= len_a_reg);
    assign stat.tb_done = (i_reg == '0) && (j_reg == '0);

    assign dir_we = cmd.fill_step && (j_reg != '0) && (j_reg <= len_b_reg);
    assign dir_waddr = {ia, jb};
    assign dir_wdata = dir;
    assign dir_raddr = {ia, jb};

    gsa_ram #(.WIDTH(2), .DEPTH(1 << AW)) u_dir (
        .clk(clk), .we(dir_we), .waddr(dir_waddr), .wdata(dir_wdata),
        .raddr(dir_raddr), .rdata(dir_rd)
    );

    logic [1:0] tb_dir;
    always_comb
    begin
        if (i_reg != '0 && j_reg != '0) tb_dir = dir_rd;
        else if (i_reg != '0) tb_dir = gsa_pkg::DirUp;
        else tb_dir = gsa_pkg::DirLeft;
    end

    assign stat.tb_last = (tb_dir == gsa_pkg::DirDiag && i_reg == LW'(1) && j_reg == LW'(1))
        || (tb_dir == gsa_pkg::DirUp && i_reg == LW'(1) && j_reg == '0)
        || (tb_dir == gsa_pkg::DirLeft && i_reg == '0 && j_reg == LW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_a_reg <= '0;
            len_b_reg <= '0;
            ovf_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            i_reg <= '0;
            j_reg <= '0;
        end
        else
        begin
            if (cmd.tb_step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.load)
            begin
                if (in_cmd == gsa_pkg::CmdLoadFirst)
                begin
                    if (len_a_reg < MaxLenL) len_a_reg <= len_a_reg + LW'(1);
                    else ovf_reg <= 1'b1;
                end
                else
                begin
                    if (len_b_reg < MaxLenL) len_b_reg <= len_b_reg + LW'(1);
                    else ovf_reg <= 1'b1;
                end
            end
            if (cmd.init_row)
            begin
                i_reg <= '0;
                j_reg <= '0;
            end
            if (cmd.fill_step)
            begin
                if (j_reg >= len_b_reg)
                begin
                    if (i_reg >= len_a_reg)
                    begin
                        j_reg <= len_b_reg;
                    end
                    else
                    begin
                        i_reg <= i_reg + LW'(1);
                        j_reg <= '0;
                    end
                end
                else
                begin
                    j_reg <= j_reg + LW'(1);
                end
            end
            if (cmd.tb_step)
            begin
                unique case (tb_dir)
                    gsa_pkg::DirDiag:
                    begin
                        i_reg <= i_reg - LW'(1);
                        j_reg <= j_reg - LW'(1);
                    end
                    gsa_pkg::DirUp:
                    begin
                        i_reg <= i_reg - LW'(1);
                    end
                    default:
                    begin
                        j_reg <= j_reg - LW'(1);
                    end
                endcase
            end
            if (cmd.clear)
            begin
                len_a_reg <= '0;
                len_b_reg <= '0;
                ovf_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (in_cmd == gsa_pkg::CmdLoadFirst && len_a_reg < MaxLenL)
                seq_a_reg[IW'(len_a_reg)] <= in_symbol;
            if (in_cmd == gsa_pkg::CmdLoadSecond && len_b_reg < MaxLenL)
                seq_b_reg[IW'(len_b_reg)] <= in_symbol;
        end
        if (cmd.fill_step)
        begin
            if (j_reg == '0)
            begin
                if (i_reg == '0)
                begin
                    row0_reg <= '0;
                    diag_reg <= '0;
                end
                else
                begin
                    diag_reg <= row0_reg;
                    row0_reg <= sat_add(row0_reg, gap_score);
                end
            end
            else if (j_reg <= len_b_reg)
            begin
                if (i_reg == '0)
                begin
                    row_reg[jb] <= l_s;
                end
                else
                begin
                    diag_reg <= up_cell;
                    row_reg[jb] <= best;
                end
            end
            if (stat.fill_done)
            begin
                if (len_b_reg != '0)
                begin
                    score_reg <= (i_reg != '0) ? best : l_s;
                end
                else
                begin
                    score_reg <= sat_add(row0_reg, gap_score);
                end
            end
        end
        if (cmd.tb_step)
        begin
            out_score_reg <= score_reg;
            out_status_reg <= ovf_reg;
            out_last_reg <= stat.tb_last;
            out_agap_reg <= tb_dir == gsa_pkg::DirLeft;
            out_bgap_reg <= tb_dir == gsa_pkg::DirUp;
            out_a_reg <= (tb_dir == gsa_pkg::DirLeft) ? 8'd0 : seq_a_reg[ia];
            out_b_reg <= (tb_dir == gsa_pkg::DirUp) ? 8'd0 : seq_b_reg[jb];
        end
    end

    assign out.valid = out_valid_reg;
    assign out.score = out_score_reg;
    assign out.first_symbol = out_a_reg;
    assign out.first_is_gap = out_agap_reg;
    assign out.second_symbol = out_b_reg;
    assign out.second_is_gap = out_bgap_reg;
    assign out.last = out_last_reg;
    assign out.status = out_status_reg;

    `GSA_ASSERT_IMPL(a_len_a, clk, rst_n, len_a_reg <= MaxLenL, "first length over capacity")
    `GSA_ASSERT_IMPL(a_len_b, clk, rst_n, len_b_reg <= MaxLenL, "second length over capacity")
    `GSA_ASSERT_NEVER(a_gap_both, clk, rst_n, out_valid_reg && out_agap_reg && out_bgap_reg, "both gaps")
endmodule
`default_nettype wire

FILE: design/global_sequence_aligner.sv
`default_nettype none
// Global sequence aligner. Load beats append one symbol per cycle to the
// first or second sequence. An align beat fills the score matrix one cell per
// cycle, row by row, with an init state ahead of each row. It then traces back
// one emitted pair at a time, with a traceback memory read ahead of each pair,
// and last clears the lengths. With both sequences empty, an align beat only
// clears them. Input is held off for the whole align, and a pending pair that
// waits on the result side stalls the traceback. The single cell datapath and
// the registered traceback memory set this pace.
module global_sequence_aligner #(
    parameter int MAX_LEN = gsa_pkg::MaxLenDefault,
    parameter int SCORE_WIDTH = gsa_pkg::ScoreWidthDefault
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    gsa_in_if.sink           in_ch,
    gsa_out_if.source        out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic signed [4:0] match_reg, mismatch_reg, gap_reg;
    gsa_pkg::cmd_t cmd;
    gsa_pkg::stat_t stat;
    logic empty;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 5'sd1;
            mismatch_reg <= -5'sd1;
            gap_reg <= -5'sd2;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                gsa_pkg::RegMatch: match_reg <= pwdata[4:0];
                gsa_pkg::RegMismatch: mismatch_reg <= pwdata[4:0];
                gsa_pkg::RegGap: gap_reg <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            gsa_pkg::RegMatch: prdata = 32'(signed'(match_reg));
            gsa_pkg::RegMismatch: prdata = 32'(signed'(mismatch_reg));
            gsa_pkg::RegGap: prdata = 32'(signed'(gap_reg));
            default: prdata = '0;
        endcase
    end

    gsa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_cmd(in_ch.cmd),
        .in_ready(in_ch.ready), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .empty(empty), .stat(stat), .cmd(cmd)
    );

    gsa_dp #(.MAX_LEN(MAX_LEN), .SCORE_WIDTH(SCORE_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_cmd(in_ch.cmd), .in_symbol(in_ch.symbol),
        .match_score(match_reg), .mismatch_score(mismatch_reg), .gap_score(gap_reg),
        .out_ready(out_ch.ready), .empty(empty), .stat(stat), .out(out_ch)
    );
endmodule
`default_nettype wire
